/* rtl/core/psv_pkg.sv */
`default_nettype none

package psv_pkg;

  localparam int unsigned MaxStagesDef = 16;
  localparam int unsigned CodeW        = 24;
  localparam int unsigned HistW        = 2 * CodeW;

  localparam logic [CodeW-1:0] CodeMax = 24'hFFFFFF;

  // Register reset values
  localparam logic [4:0]       StageCountRst = 5'd1;
  localparam logic [CodeW-1:0] HeadMarginRst = 24'h400000;
  localparam logic [CodeW-1:0] TailMarginRst = 24'h199999;
  localparam logic [7:0]       ErrorLimitRst = 8'd10;

  typedef enum logic [1:0] {
    ModeLoad    = 2'd0,
    ModeSample  = 2'd1,
    ModeRestart = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RegStageCount = 2'd0,
    RegHeadMargin = 2'd1,
    RegTailMargin = 2'd2,
    RegErrorLimit = 2'd3
  } reg_idx_e;

  // Flip the sign bit to get an offset code, scale to 24 bits.
  function automatic logic [CodeW-1:0] adc_to_code(input logic [15:0] raw);
    return {~raw[15], raw[14:0], 8'h00};
  endfunction

  // 2*last1 - last2, saturated to the code range.
  function automatic logic [CodeW-1:0] extrapolate(input logic [CodeW-1:0] last1,
                                                   input logic [CodeW-1:0] last2);
    logic [CodeW+1:0] diff;
    diff = {1'b0, last1, 1'b0} - {2'b00, last2};
    if (diff[CodeW+1]) begin
      return '0;
    end else if (diff[CodeW]) begin
      return CodeMax;
    end
    return diff[CodeW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/psv_hist_ram.sv */
`default_nettype none

module psv_hist_ram
  import psv_pkg::*;
#(
  parameter int unsigned DEPTH = 6 * MaxStagesDef,
  parameter int unsigned AW    = $clog2(6 * MaxStagesDef)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_a_i,
  input  wire logic [AW-1:0]    rd_addr_b_i,
  output logic      [HistW-1:0] rd_data_a_o,
  output logic      [HistW-1:0] rd_data_b_o,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [HistW-1:0] wr_data_i
);

  logic [HistW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem[rd_addr_a_i];
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pulse_stage_sample_validator.sv */
// Sample validator for a repeating multi-stage pulse.
// Input stream: tuser carries the item kind (load predicted code, ADC sample
// pair, restart); tdata carries stage select, predicted code and raw words.
// Output stream: one beat per sample; tlast marks the tail sample of the last
// stage, tuser carries head/substituted/buffer flags.
// APB port: stage count, head margin, tail margin, error limit at 0x0..0xC;
// write only while the block is idle.
// A sample is read from two memories at accept (predicted code, and two
// history slots from a dual-read history RAM), checked in the check stage and
// written back as it moves into the output register. No new item is accepted
// while a sample sits in the check stage (history read-modify-write).
// Loads and restarts take effect at accept, one per cycle if no sample waits.
// While the output beat is stalled the next sample may still enter and
// waits in the check stage; further input stalls until the output drains.
// Reset sets stage 0, head phase, history invalid, counts zero, registers to
// their defaults; memory contents are not cleared.
`default_nettype none

module pulse_stage_sample_validator
  import psv_pkg::*;
#(
  parameter int unsigned MAX_STAGES = MaxStagesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [3:0] stage_select, [27:4] predicted_code, [43:28] raw_current,
  // [59:44] raw_voltage, [63:60] zero
  input  wire logic [63:0]  s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]   s_axis_tuser,
  // output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [3:0] stage_index, [27:4] current_code, [51:28] voltage_code,
  // [83:52] cycle_count, [99:84] error_count, [103:100] zero
  output logic      [103:0] m_axis_tdata,
  // [0] is_head, [1] substituted, [2] buffer_select
  output logic      [2:0]   m_axis_tuser,
  output logic              m_axis_tlast,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  localparam int unsigned PW  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned HD  = 6 * MAX_STAGES;
  localparam int unsigned HAW = $clog2(HD);

  // configuration registers
  logic [4:0]       stage_count_q;
  logic [CodeW-1:0] head_margin_q, tail_margin_q;
  logic [7:0]       error_limit_q;

  // control state
  logic [PW-1:0] ptr_q, ptr_d;
  logic          tail_q, tail_d;
  logic [1:0]    newest_q, newest_d;
  logic [2:0]    slot_valid_q, slot_valid_d;
  logic [31:0]   cycles_q, cycles_d;
  logic [15:0]   errors_q, errors_d;
  logic          ping_q, ping_d;

  // check stage
  logic        s1_valid_q, s1_valid_d;
  logic [15:0] s1_cur_raw_q, s1_volt_raw_q;

  // output register
  logic         m_valid_q, m_valid_d;
  logic [103:0] m_data_q;
  logic [2:0]   m_user_q;
  logic         m_last_q;

  logic             in_fire, load_we, sample_fire, restart_fire, s1_done;
  mode_e            in_mode;
  logic [1:0]       last1, last2;
  logic [CodeW-1:0] pred_rd_q;
  logic [HistW-1:0] hist_a, hist_b;
  logic [HAW-1:0]   rd_addr_a, rd_addr_b, wr_addr;

  logic [CodeW-1:0] margin, hi, lo, cur_in, volt_in, cur_res, volt_res;
  logic [CodeW:0]   hi_sum;
  logic             check, miss, cend, drop;
  logic [15:0]      err_after;
  logic [PW:0]      cnt_eff, ptr_inc;

  function automatic logic [HAW-1:0] hist_addr(input logic tail, input logic [1:0] slot,
                                               input logic [PW-1:0] stg);
    logic [HAW:0] a;
    a = (HAW+1)'(stg);
    if (slot == 2'd1) begin
      a = a + (HAW+1)'(MAX_STAGES);
    end else if (slot == 2'd2) begin
      a = a + (HAW+1)'(2 * MAX_STAGES);
    end
    if (tail) begin
      a = a + (HAW+1)'(3 * MAX_STAGES);
    end
    return a[HAW-1:0];
  endfunction

  // ---------------- accept ----------------
  assign s_axis_tready = !s1_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_mode       = mode_e'(s_axis_tuser);

  always_comb begin
    load_we      = 1'b0;
    sample_fire  = 1'b0;
    restart_fire = 1'b0;
    case (in_mode)
      ModeLoad:    load_we      = in_fire && (32'(s_axis_tdata[3:0]) < MAX_STAGES);
      ModeSample:  sample_fire  = in_fire;
      ModeRestart: restart_fire = in_fire;
      default:     ;
    endcase
  end

  always_comb begin
    case (newest_q)
      2'd0:    begin last1 = 2'd1; last2 = 2'd2; end
      2'd1:    begin last1 = 2'd2; last2 = 2'd0; end
      2'd2:    begin last1 = 2'd0; last2 = 2'd1; end
      default: begin last1 = 2'd1; last2 = 2'd2; end
    endcase
  end

  // ---------------- predicted code store ----------------
  logic [CodeW-1:0] pred_mem [MAX_STAGES];

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      pred_mem[PW'(s_axis_tdata[3:0])] <= s_axis_tdata[27:4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_fire) begin
      pred_rd_q <= pred_mem[ptr_q];
    end
  end

  // ---------------- history store ----------------
  assign rd_addr_a = hist_addr(tail_q, last1, ptr_q);
  assign rd_addr_b = hist_addr(tail_q, last2, ptr_q);
  assign wr_addr   = hist_addr(tail_q, newest_q, ptr_q);

  psv_hist_ram #(
    .DEPTH(HD),
    .AW   (HAW)
  ) u_hist (
    .clk_i      (clk_i),
    .rd_en_i    (sample_fire),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .rd_data_a_o(hist_a),
    .rd_data_b_o(hist_b),
    .wr_en_i    (s1_done),
    .wr_addr_i  (wr_addr),
    .wr_data_i  ({cur_res, volt_res})
  );

  always_ff @(posedge clk_i) begin
    if (sample_fire) begin
      s1_cur_raw_q  <= s_axis_tdata[43:28];
      s1_volt_raw_q <= s_axis_tdata[59:44];
    end
  end

  // ---------------- check stage ----------------
  assign s1_done = s1_valid_q && (!m_valid_q || m_axis_tready);

  always_comb begin
    margin  = tail_q ? tail_margin_q : head_margin_q;
    hi_sum  = {1'b0, pred_rd_q} + {1'b0, margin};
    hi      = hi_sum[CodeW] ? CodeMax : hi_sum[CodeW-1:0];
    lo      = (pred_rd_q > margin) ? (pred_rd_q - margin) : '0;
    cur_in  = adc_to_code(s1_cur_raw_q);
    volt_in = adc_to_code(s1_volt_raw_q);
    check   = slot_valid_q[last1] && slot_valid_q[last2];
    miss    = check && ((cur_in > hi) || (cur_in < lo));
    if (miss) begin
      cur_res  = extrapolate(hist_a[HistW-1:CodeW], hist_b[HistW-1:CodeW]);
      volt_res = extrapolate(hist_a[CodeW-1:0], hist_b[CodeW-1:0]);
    end else begin
      cur_res  = cur_in;
      volt_res = volt_in;
    end
    err_after = (miss && (errors_q != 16'hFFFF)) ? (errors_q + 16'd1) : errors_q;

    // stage count zero acts as one, above the store depth saturates
    if (stage_count_q == 5'd0) begin
      cnt_eff = (PW+1)'(1);
    end else if (32'(stage_count_q) > MAX_STAGES) begin
      cnt_eff = (PW+1)'(MAX_STAGES);
    end else begin
      cnt_eff = (PW+1)'(stage_count_q);
    end
    ptr_inc = {1'b0, ptr_q} + (PW+1)'(1);
    cend    = tail_q && (ptr_inc >= cnt_eff);
    drop    = cend && (err_after > {8'h00, error_limit_q});
  end

  // ---------------- control next state ----------------
  always_comb begin
    ptr_d        = ptr_q;
    tail_d       = tail_q;
    newest_d     = newest_q;
    slot_valid_d = slot_valid_q;
    cycles_d     = cycles_q;
    errors_d     = errors_q;
    ping_d       = ping_q;
    if (restart_fire) begin
      ptr_d        = '0;
      tail_d       = 1'b0;
      newest_d     = 2'd0;
      slot_valid_d = '0;
      cycles_d     = '0;
      errors_d     = '0;
      ping_d       = 1'b0;
    end else if (s1_done) begin
      tail_d       = !tail_q;
      slot_valid_d = slot_valid_q | (3'b001 << newest_q);
      errors_d     = err_after;
      if (tail_q) begin
        ptr_d = ptr_inc[PW-1:0];
      end
      if (cend) begin
        ptr_d    = '0;
        cycles_d = cycles_q + 32'd1;
        ping_d   = !ping_q;
        newest_d = last2;
        if (drop) begin
          newest_d     = 2'd0;
          slot_valid_d = '0;
          errors_d     = '0;
        end
      end
    end
  end

  assign s1_valid_d = sample_fire || (s1_valid_q && !s1_done);
  assign m_valid_d  = s1_done || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q        <= '0;
      tail_q       <= 1'b0;
      newest_q     <= 2'd0;
      slot_valid_q <= '0;
      cycles_q     <= '0;
      errors_q     <= '0;
      ping_q       <= 1'b0;
      s1_valid_q   <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      ptr_q        <= ptr_d;
      tail_q       <= tail_d;
      newest_q     <= newest_d;
      slot_valid_q <= slot_valid_d;
      cycles_q     <= cycles_d;
      errors_q     <= errors_d;
      ping_q       <= ping_d;
      s1_valid_q   <= s1_valid_d;
      m_valid_q    <= m_valid_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i) begin
    if (s1_done) begin
      m_data_q <= {4'h0, errors_d, cycles_d, volt_res, cur_res, 4'(ptr_q)};
      m_user_q <= {ping_q, miss, !tail_q};
      m_last_q <= cend;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------- configuration port ----------------
  reg_idx_e cfg_idx;
  logic     cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= StageCountRst;
      head_margin_q <= HeadMarginRst;
      tail_margin_q <= TailMarginRst;
      error_limit_q <= ErrorLimitRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegStageCount: stage_count_q <= pwdata[4:0];
        RegHeadMargin: head_margin_q <= pwdata[CodeW-1:0];
        RegTailMargin: tail_margin_q <= pwdata[CodeW-1:0];
        RegErrorLimit: error_limit_q <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegStageCount: prdata = {27'h0, stage_count_q};
      RegHeadMargin: prdata = {8'h00, head_margin_q};
      RegTailMargin: prdata = {8'h00, tail_margin_q};
      RegErrorLimit: prdata = {24'h0, error_limit_q};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb
  import psv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ModeUnused    = 2'd3;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned ItemsPerPhase = 160;
  localparam int unsigned QuietLimit    = 3000;
  localparam int unsigned RxHoldBeat    = 250;
  localparam int unsigned RxHoldCycles  = 300;
  localparam logic [15:0] RawEdges [4]  = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  sel;
    logic [23:0] pred;
    logic [15:0] rcur;
    logic [15:0] rvolt;
  } item_t;

  typedef struct packed {
    logic [3:0]  stage;
    logic        head;
    logic [23:0] cur;
    logic [23:0] volt;
    logic        subst;
    logic        cend;
    logic        bsel;
    logic [31:0] cycles;
    logic [15:0] errs;
  } sample_res_t;

  typedef struct packed {
    item_t       it;
    bit          typed;
    sample_res_t res;
  } dir_row_t;

  // Default registers: one stage, head 0x400000, tail 0x199999, limit 10.
  localparam dir_row_t StimRows [21] = '{
    '{'{ModeLoad,    4'd0,  24'h800000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ModeLoad,    4'd15, 24'hFFFFFF, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ModeUnused,  4'hF,  24'hFFFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h0000, 16'hFFFF}, 1'b1,
      '{4'd0, 1'b1, 24'h800000, 24'h7FFF00, 1'b0, 1'b0, 1'b0, 32'd0, 16'd0}},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h8000, 16'h7FFF}, 1'b1,
      '{4'd0, 1'b0, 24'h000000, 24'hFFFF00, 1'b0, 1'b1, 1'b0, 32'd1, 16'd0}},
    '{'{ModeSample,  4'd0,  24'h000000, 16'hFFFF, 16'h8000}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h7FFF, 16'h0000}, 1'b0, '0},
    // history now valid: low then high current gets replaced
    '{'{ModeSample,  4'd0,  24'h000000, 16'h8000, 16'h1234}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h7FFF, 16'h4321}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h0000, 16'hFFFF}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h0000, 16'h0000}, 1'b0, '0},
    // window low edge clamps to zero
    '{'{ModeLoad,    4'd0,  24'h000000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'hFFFF, 16'hAAAA}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h8000, 16'h5555}, 1'b0, '0},
    // window high edge clamps to full scale
    '{'{ModeLoad,    4'd0,  24'hFFFFFF, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h7FFF, 16'h0F0F}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h0000, 16'hF0F0}, 1'b0, '0},
    '{'{ModeRestart, 4'd0,  24'h000000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'h1234, 16'h5678}, 1'b1,
      '{4'd0, 1'b1, 24'h923400, 24'hD67800, 1'b0, 1'b0, 1'b0, 32'd0, 16'd0}},
    '{'{ModeUnused,  4'h5,  24'h123456, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{ModeSample,  4'd0,  24'h000000, 16'hABCD, 16'h00FF}, 1'b0, '0}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // [3:0] sel, [27:4] pred, [43:28] cur, [59:44] volt
  logic [1:0]   s_axis_tuser = '0;   // [1:0] mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // [3:0] stage, [27:4] cur, [51:28] volt,
                                     // [83:52] cycles, [99:84] errors
  logic [2:0]   m_axis_tuser;        // [0] head, [1] substituted, [2] buffer
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  pulse_stage_sample_validator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5ns clk_i = ~clk_i;

  // validator state mirror
  logic [4:0]  cfg_stages = StageCountRst;
  logic [23:0] cfg_head   = HeadMarginRst;
  logic [23:0] cfg_tail   = TailMarginRst;
  logic [7:0]  cfg_limit  = ErrorLimitRst;
  logic [23:0] pred_code  [MaxStagesDef];
  bit          pred_known [MaxStagesDef];
  logic [47:0] hist_mem   [2][3][MaxStagesDef];
  bit          hist_known [2][3][MaxStagesDef];
  logic [2:0]  slot_ok = '0;
  int unsigned newest = 0;
  int unsigned stage_ptr = 0;
  logic        tail_ph = 1'b0;
  logic [31:0] cyc_cnt = '0;
  logic [15:0] err_cnt = '0;
  logic        ping = 1'b0;

  sample_res_t pending_samples [$];
  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  int unsigned subst_seen = 0;
  int unsigned cend_seen = 0;
  int unsigned loads_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  function automatic logic [23:0] code_of(logic [15:0] raw);
    return {raw ^ 16'h8000, 8'h00};
  endfunction

  function automatic logic [23:0] extend_trend(logic [23:0] last, logic [23:0] prior);
    longint v;
    v = 2 * longint'(last) - longint'(prior);
    if (v < 0) return '0;
    if (v > longint'(CodeMax)) return CodeMax;
    return v[23:0];
  endfunction

  // True when the current code at the pointed stage would be replaced.
  function automatic bit falls_outside(logic [23:0] c);
    logic [24:0] hi;
    logic [23:0] lo, m, p;
    m = tail_ph ? cfg_tail : cfg_head;
    p = pred_code[stage_ptr];
    hi = {1'b0, p} + {1'b0, m};
    if (hi > {1'b0, CodeMax}) hi = {1'b0, CodeMax};
    lo = (p > m) ? p - m : '0;
    return slot_ok[(newest + 1) % 3] && slot_ok[(newest + 2) % 3] &&
           ({1'b0, c} > hi || c < lo);
  endfunction

  task automatic apply_item(input item_t it, output bit has, output sample_res_t r);
    int unsigned n, l1, l2;
    logic [47:0] a, b;
    logic [23:0] cur, volt;
    has = 1'b0;
    r = '0;
    case (it.mode)
      ModeLoad: begin
        pred_code[it.sel] = it.pred;
        pred_known[it.sel] = 1'b1;
        loads_sent++;
      end
      ModeRestart: begin
        slot_ok = '0;
        newest = 0;
        stage_ptr = 0;
        tail_ph = 1'b0;
        cyc_cnt = '0;
        err_cnt = '0;
        ping = 1'b0;
        restarts_sent++;
      end
      ModeSample: begin
        n = (cfg_stages == 0) ? 1 : (cfg_stages > MaxStagesDef ? MaxStagesDef : cfg_stages);
        l1 = (newest + 1) % 3;
        l2 = (newest + 2) % 3;
        cur = code_of(it.rcur);
        volt = code_of(it.rvolt);
        r.stage = 4'(stage_ptr);
        r.head = !tail_ph;
        r.bsel = ping;
        if (falls_outside(cur)) begin
          a = hist_mem[tail_ph][l1][stage_ptr];
          b = hist_mem[tail_ph][l2][stage_ptr];
          cur = extend_trend(a[47:24], b[47:24]);
          volt = extend_trend(a[23:0], b[23:0]);
          r.subst = 1'b1;
          if (err_cnt != 16'hFFFF) err_cnt++;
        end
        hist_mem[tail_ph][newest][stage_ptr] = {cur, volt};
        hist_known[tail_ph][newest][stage_ptr] = 1'b1;
        slot_ok[newest] = 1'b1;
        if (tail_ph) begin
          tail_ph = 1'b0;
          stage_ptr++;
          if (stage_ptr >= n) begin
            r.cend = 1'b1;
            stage_ptr = 0;
            cyc_cnt++;
            ping = !ping;
            newest = (newest + 2) % 3;
            // too many substitutions this run: drop all history
            if (err_cnt > cfg_limit) begin
              newest = 0;
              slot_ok = '0;
              err_cnt = '0;
            end
          end
        end else begin
          tail_ph = 1'b1;
        end
        r.cur = cur;
        r.volt = volt;
        r.cycles = cyc_cnt;
        r.errs = err_cnt;
        has = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s: got %h want %h", beats_seen, name, got, want));
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // written at this edge; turn straight into a read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegStageCount: cfg_stages = val[4:0];
      RegHeadMargin: cfg_head = val[23:0];
      RegTailMargin: cfg_tail = val[23:0];
      default:       cfg_limit = val[7:0];
    endcase
    if (rd !== val) report_mismatch($sformatf("reg %0d reads %h, wrote %h", idx, rd, val));
    @(posedge clk_i);
  endtask

  task automatic send_item(input item_t it, input bit typed, input sample_res_t typed_res);
    int unsigned gap;
    bit has;
    sample_res_t r;
    if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'h0, it.rvolt, it.rcur, it.pred, it.sel};
    s_axis_tuser  <= it.mode;
    s_axis_tvalid <= 1'b1;
    @(negedge clk_i);
    while (s_axis_tready !== 1'b1) @(negedge clk_i);
    // beat moves at the coming edge
    apply_item(it, has, r);
    if (has) pending_samples.push_back(typed ? typed_res : r);
    @(posedge clk_i);
  endtask

  task automatic random_item(output item_t it);
    int unsigned pick, m, stg;
    longint t;
    it.sel   = 4'($urandom);
    it.pred  = 24'($urandom);
    it.rcur  = 16'($urandom);
    it.rvolt = 16'($urandom);
    stg = stage_ptr;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      it.mode = ModeLoad;
      if ($urandom_range(0, 4) == 0) it.pred = $urandom_range(0, 1) ? CodeMax : '0;
    end else if (pick < 8) begin
      it.mode = ModeRestart;
    end else if (pick < 9) begin
      it.mode = ModeUnused;
    end else begin
      it.mode = ModeSample;
      if ($urandom_range(0, 9) < 7 && pred_known[stg]) begin
        // land near the predicted code, mostly inside the window
        m = tail_ph ? cfg_tail : cfg_head;
        t = longint'(pred_code[stg]) + longint'($urandom_range(0, 2 * m)) - longint'(m);
        if (t < 0) t = 0;
        if (t > longint'(CodeMax)) t = longint'(CodeMax);
        it.rcur = t[23:8] ^ 16'h8000;
      end else if ($urandom_range(0, 9) == 0) begin
        it.rcur = RawEdges[$urandom_range(0, 3)];
      end
      // never read a predicted code or a history entry that was never written
      if (!pred_known[stg]) begin
        it.mode = ModeLoad;
        it.sel = 4'(stg);
      end else if (falls_outside(code_of(it.rcur)) &&
                   !(hist_known[tail_ph][(newest + 1) % 3][stg] &&
                     hist_known[tail_ph][(newest + 2) % 3][stg])) begin
        it.mode = ModeRestart;
      end
    end
  endtask

  function automatic logic [23:0] pick_margin();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CodeMax;
      2:       return 24'($urandom_range(0, 24'h0FFFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : drain
    sample_res_t got, want;
    int unsigned w;
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
      w = rx_idle ? $urandom_range(0, 14) : 0;
      // one long hold-off so the input side backs up
      if (!held && beats_seen == RxHoldBeat) begin
        w = RxHoldCycles;
        held = 1'b1;
      end
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
      while (m_axis_tvalid !== 1'b1) @(negedge clk_i);
      got.stage  = m_axis_tdata[3:0];
      got.cur    = m_axis_tdata[27:4];
      got.volt   = m_axis_tdata[51:28];
      got.cycles = m_axis_tdata[83:52];
      got.errs   = m_axis_tdata[99:84];
      got.head   = m_axis_tuser[0];
      got.subst  = m_axis_tuser[1];
      got.bsel   = m_axis_tuser[2];
      got.cend   = m_axis_tlast;
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with no sample pending", beats_seen));
      end else begin
        want = pending_samples.pop_front();
        cmp_field("stage_index", 32'(got.stage), 32'(want.stage));
        cmp_field("is_head", 32'(got.head), 32'(want.head));
        cmp_field("current_code", 32'(got.cur), 32'(want.cur));
        cmp_field("voltage_code", 32'(got.volt), 32'(want.volt));
        cmp_field("substituted", 32'(got.subst), 32'(want.subst));
        cmp_field("cycle_end", 32'(got.cend), 32'(want.cend));
        cmp_field("buffer_select", 32'(got.bsel), 32'(want.bsel));
        cmp_field("cycle_count", got.cycles, want.cycles);
        cmp_field("error_count", 32'(got.errs), 32'(want.errs));
      end
      beats_seen++;
      if (got.subst === 1'b1) subst_seen++;
      if (got.cend === 1'b1) cend_seen++;
      @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == QuietLimit) begin
        $display("no beat moved for %0d cycles", QuietLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    item_t it;
    int unsigned sent;
    logic [4:0] sc;
    logic [23:0] hm, tm;
    logic [7:0] el;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(StimRows); i++) begin
      send_item(StimRows[i].it, StimRows[i].typed, StimRows[i].res);
    end
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      hm = pick_margin();
      tm = pick_margin();
      el = $urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom);
      sc = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4));
      case (ph)
        0: begin
          sc = 5'd1;
          hm = '0;
          tm = '0;
          el = 8'd0;
        end
        1: begin
          sc = 5'(MaxStagesDef);
          hm = CodeMax;
          tm = CodeMax;
          el = 8'hFF;
        end
        2: sc = 5'd0;
        3: sc = 5'd31;
        default: ;
      endcase
      write_reg(RegStageCount, 32'(sc));
      write_reg(RegHeadMargin, 32'(hm));
      write_reg(RegTailMargin, 32'(tm));
      write_reg(RegErrorLimit, 32'(el));
      sent = 0;
      while (sent < ItemsPerPhase) begin
        random_item(it);
        send_item(it, 1'b0, '0);
        if (it.mode != ModeUnused) sent++;
      end
    end
    settle();
    $display("checked %0d sample beats: %0d substituted, %0d cycle ends",
             beats_seen, subst_seen, cend_seen);
    $display("%0d loads, %0d restarts, %0d register settings after defaults",
             loads_sent, restarts_sent, NumPhases);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
